@@ sv/rrd_pkg.sv @@
// Package for the row run-length delta frame decoder.
// Holds the parser phase type, the item and result structures and fixed widths.
// It has no dependencies.
`default_nettype none

package rrd_pkg;

  // Fixed field widths.
  localparam int BYTE_W = 8;
  localparam int ADDR_W = 19;
  localparam int WORD_W = 16;

  // Parser phases: header bytes, run count, run x, run length, fill and literal bytes.
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_H1    = 4'd1,
    PH_H2    = 4'd2,
    PH_H3    = 4'd3,
    PH_COUNT = 4'd4,
    PH_X0    = 4'd5,
    PH_X1    = 4'd6,
    PH_LEN   = 4'd7,
    PH_FILLV = 4'd8,
    PH_FILLN = 4'd9,
    PH_LIT   = 4'd10
  } phase_t;

  // One input item as held in the input register.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              frame_start;
  } item_t;

  // One result item.
  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] pixel_address;
    logic [BYTE_W-1:0] pixel_value;
    logic [BYTE_W-1:0] span_length;
    logic              frame_end;
    logic              frame_abort;
  } result_t;

endpackage

`default_nettype wire

@@ sv/rrd_in_stage.sv @@
// Input register of the decoder: captures one byte transaction at a time.
// Uses item_t from rrd_pkg; the parser drains it through the take signal.
`default_nettype none

module rrd_in_stage
  import rrd_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  wire   take,
  output logic  held_valid,
  output item_t held_item
);

  logic accept;

  // The register can refill in the same cycle as it is drained.
  assign in_stall = held_valid && !take;
  assign accept   = in_valid && !in_stall;

  // Valid flag of the held item.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  // Payload of the held item.
  always_ff @(posedge clk) begin
    if (accept) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

@@ sv/rrd_parser.sv @@
// Parser state and single-pass decode of one byte into at most one result.
// Uses phase_t, item_t and result_t from rrd_pkg.
`default_nettype none

module rrd_parser
  import rrd_pkg::*;
#(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  wire     clk,
  input  wire     rst,
  input  wire     step,
  input  item_t   item,
  output logic    res_valid,
  output result_t res
);

  localparam int SIZE = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int CW0  = $clog2(SIZE + 65536 + 256) + 1;
  localparam int CW   = (CW0 > ADDR_W) ? CW0 : ADDR_W;
  localparam int RW   = $clog2(FRAME_HEIGHT + 1);
  localparam logic [CW-1:0]     SIZE_C   = CW'(SIZE);
  localparam logic [CW-1:0]     WIDTH_C  = CW'(FRAME_WIDTH);
  localparam logic [WORD_W-1:0] HEIGHT_C = WORD_W'(FRAME_HEIGHT);

  phase_t              phase, phase_next;
  logic [WORD_W-1:0]   first_row, first_row_next;
  logic [WORD_W-1:0]   last_row, last_row_next;
  logic [WORD_W-1:0]   current_row, current_row_next;
  logic [BYTE_W-1:0]   runs_left, runs_left_next;
  logic [WORD_W-1:0]   run_x, run_x_next;
  logic [BYTE_W-1:0]   literal_left, literal_left_next;
  logic [CW-1:0]       write_address, write_address_next;
  logic [BYTE_W-1:0]   fill_byte, fill_byte_next;
  logic                skip_span, skip_span_next;

  logic [BYTE_W-1:0]   b;
  logic [WORD_W-1:0]   row_plus;
  logic [WORD_W-1:0]   h3_last;
  logic                row_done;
  logic                h3_done;
  logic [BYTE_W-1:0]   runs_dec;
  logic [BYTE_W-1:0]   lit_dec;
  logic                end_done;
  logic [CW-1:0]       run_addr;
  logic                run_abort;
  logic                fill_ok;
  logic                lit_skip;

  assign b = item.data_byte;

  // Row bookkeeping: next row and the end-of-frame tests.
  assign row_plus = current_row + WORD_W'(1);
  assign h3_last  = {b, last_row[7:0]};
  assign row_done = (row_plus > last_row) || (row_plus >= HEIGHT_C);
  assign h3_done  = (first_row > h3_last) || (first_row >= HEIGHT_C);
  assign runs_dec = runs_left - BYTE_W'(1);
  assign lit_dec  = literal_left - BYTE_W'(1);
  assign end_done = (runs_dec == '0) && row_done;

  // Span start and bounds. The row is below the frame height whenever a run is parsed.
  assign run_addr  = CW'(current_row[RW-1:0]) * WIDTH_C + CW'(run_x);
  assign run_abort = run_addr >= SIZE_C;
  assign fill_ok   = (b != '0) && ((write_address + CW'(b)) <= SIZE_C);
  assign lit_skip  = (run_addr + CW'(b)) > SIZE_C;

  // Next-state logic of the parser.
  always_comb begin
    phase_next         = phase;
    first_row_next     = first_row;
    last_row_next      = last_row;
    current_row_next   = current_row;
    runs_left_next     = runs_left;
    run_x_next         = run_x;
    literal_left_next  = literal_left;
    write_address_next = write_address;
    fill_byte_next     = fill_byte;
    skip_span_next     = skip_span;
    if (item.frame_start) begin
      first_row_next = {8'h00, b};
      phase_next     = PH_H1;
    end else begin
      case (phase)
        PH_H1: begin
          first_row_next[15:8] = b;
          phase_next           = PH_H2;
        end
        PH_H2: begin
          last_row_next = {8'h00, b};
          phase_next    = PH_H3;
        end
        PH_H3: begin
          last_row_next[15:8] = b;
          current_row_next    = first_row;
          phase_next          = h3_done ? PH_IDLE : PH_COUNT;
        end
        PH_COUNT: begin
          runs_left_next = b;
          if (b == '0) begin
            current_row_next = row_plus;
            phase_next       = row_done ? PH_IDLE : PH_COUNT;
          end else begin
            phase_next = PH_X0;
          end
        end
        PH_X0: begin
          run_x_next = {8'h00, b};
          phase_next = PH_X1;
        end
        PH_X1: begin
          run_x_next[15:8] = b;
          phase_next       = PH_LEN;
        end
        PH_LEN: begin
          write_address_next = run_addr;
          if (run_abort) begin
            phase_next = PH_IDLE;
          end else if (b == '0) begin
            phase_next = PH_FILLV;
          end else begin
            literal_left_next = b;
            skip_span_next    = lit_skip;
            phase_next        = PH_LIT;
          end
        end
        PH_FILLV: begin
          fill_byte_next = b;
          phase_next     = PH_FILLN;
        end
        PH_FILLN: begin
          runs_left_next = runs_dec;
          if (runs_dec == '0) begin
            current_row_next = row_plus;
            phase_next       = row_done ? PH_IDLE : PH_COUNT;
          end else begin
            phase_next = PH_X0;
          end
        end
        PH_LIT: begin
          write_address_next = write_address + CW'(1);
          literal_left_next  = lit_dec;
          if (lit_dec == '0) begin
            runs_left_next = runs_dec;
            if (runs_dec == '0) begin
              current_row_next = row_plus;
              phase_next       = row_done ? PH_IDLE : PH_COUNT;
            end else begin
              phase_next = PH_X0;
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Result logic of the parser.
  always_comb begin
    res = '0;
    if (!item.frame_start) begin
      case (phase)
        PH_H3: begin
          res.frame_end = h3_done;
        end
        PH_COUNT: begin
          res.frame_end = (b == '0) && row_done;
        end
        PH_LEN: begin
          res.frame_abort = run_abort;
        end
        PH_FILLN: begin
          if (fill_ok) begin
            res.write_enable  = 1'b1;
            res.pixel_address = write_address[ADDR_W-1:0];
            res.pixel_value   = fill_byte;
            res.span_length   = b;
          end
          res.frame_end = end_done;
        end
        PH_LIT: begin
          if (!skip_span) begin
            res.write_enable  = 1'b1;
            res.pixel_address = write_address[ADDR_W-1:0];
            res.pixel_value   = b;
            res.span_length   = BYTE_W'(1);
          end
          res.frame_end = (lit_dec == '0) && end_done;
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  assign res_valid = res.write_enable || res.frame_end || res.frame_abort;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  // Header, row and run registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_row     <= '0;
      last_row      <= '0;
      current_row   <= '0;
      runs_left     <= '0;
      run_x         <= '0;
      literal_left  <= '0;
      write_address <= '0;
      fill_byte     <= '0;
      skip_span     <= 1'b0;
    end else if (step) begin
      first_row     <= first_row_next;
      last_row      <= last_row_next;
      current_row   <= current_row_next;
      runs_left     <= runs_left_next;
      run_x         <= run_x_next;
      literal_left  <= literal_left_next;
      write_address <= write_address_next;
      fill_byte     <= fill_byte_next;
      skip_span     <= skip_span_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/rrd_out_stage.sv @@
// Result register of the decoder: holds one result until it is taken.
// Uses result_t from rrd_pkg; tells the parser when it may advance.
`default_nettype none

module rrd_out_stage
  import rrd_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     have_item,
  input  wire     res_valid,
  input  result_t res,
  output logic    step,
  output logic    out_valid,
  input  wire     out_stall,
  output result_t out_res
);

  // The parser advances when it holds a byte and the register is empty or is drained this cycle.
  assign step = have_item && (!out_valid || !out_stall);

  // Valid flag of the held result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload of the held result.
  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

@@ sv/row_rle_delta_frame_decoder.sv @@
// Row run-length delta frame decoder: delta-frame bytes in, span writes out.
// A byte passes the input register and the parser, and its result is then
// registered in the result register, provided the result register is free.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// single-pass parser between the input register and the result register.
// Reset: synchronous; the parser returns to idle and both registers empty.
// Depends on rrd_pkg, rrd_in_stage, rrd_parser and rrd_out_stage.
`default_nettype none

module row_rle_delta_frame_decoder
  import rrd_pkg::*;
#(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [BYTE_W-1:0]  data_byte,
  input  wire                frame_start,
  output logic               out_valid,
  input  wire                out_stall,
  output logic               write_enable,
  output logic [ADDR_W-1:0]  pixel_address,
  output logic [BYTE_W-1:0]  pixel_value,
  output logic [BYTE_W-1:0]  span_length,
  output logic               frame_end,
  output logic               frame_abort
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.data_byte   = data_byte;
  assign in_item.frame_start = frame_start;

  rrd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (step),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  rrd_parser #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (held_item),
    .res_valid (res_valid),
    .res       (res)
  );

  rrd_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .have_item (held_valid),
    .res_valid (res_valid),
    .res       (res),
    .step      (step),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // Result fields onto their ports.
  assign write_enable  = out_res.write_enable;
  assign pixel_address = out_res.pixel_address;
  assign pixel_value   = out_res.pixel_value;
  assign span_length   = out_res.span_length;
  assign frame_end     = out_res.frame_end;
  assign frame_abort   = out_res.frame_abort;

endmodule

`default_nettype wire

@@ tb/sv/rrd_span_checker.sv @@
`timescale 1ns / 1ps
// Checker for the row run-length delta frame decoder: it watches both channels,
// predicts the span writes and frame reports, and compares them in order.
// Depends on rrd_pkg for the phase type and the result structure.
module rrd_span_checker
  import rrd_pkg::*;
#(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              frame_start,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              write_enable,
  input  logic [ADDR_W-1:0] pixel_address,
  input  logic [BYTE_W-1:0] pixel_value,
  input  logic [BYTE_W-1:0] span_length,
  input  logic              frame_end,
  input  logic              frame_abort,
  output int                error_count,
  output int                pending_results
);

  localparam int unsigned PIXELS = FRAME_WIDTH * FRAME_HEIGHT;

  // Shadow copy of the parser state.
  phase_t            ph;
  logic [WORD_W-1:0] first_row;
  logic [WORD_W-1:0] last_row;
  logic [WORD_W-1:0] cur_row;
  logic [BYTE_W-1:0] runs_left;
  logic [WORD_W-1:0] run_x;
  logic [BYTE_W-1:0] lit_left;
  logic [31:0]       span_addr;
  logic [BYTE_W-1:0] fill_val;
  logic              skip_span;

  // Span writes and frame reports still awaited, oldest first.
  result_t span_expect_q[$];

  initial error_count = 0;

  // Prints one line for a mismatch and counts it.
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Tests the current row against the header range and the frame height.
  task automatic check_row(output logic done);
    if (cur_row > last_row || cur_row >= FRAME_HEIGHT) begin
      ph   = PH_IDLE;
      done = 1'b1;
    end else begin
      ph   = PH_COUNT;
      done = 1'b0;
    end
  endtask

  task automatic advance_row(output logic done);
    cur_row = cur_row + 16'd1;
    check_row(done);
  endtask

  // Closes one run and moves on to the next run or the next row.
  task automatic close_run(output logic done);
    runs_left = runs_left - 8'd1;
    if (runs_left == 8'd0) begin
      advance_row(done);
    end else begin
      ph   = PH_X0;
      done = 1'b0;
    end
  endtask

  // Works out the result, if any, that one accepted byte causes.
  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic start,
                             output logic has_result, output result_t res);
    logic we;
    logic fend;
    logic fabort;
    we     = 1'b0;
    fend   = 1'b0;
    fabort = 1'b0;
    res    = '0;
    if (start) begin
      first_row = {8'h00, b};
      ph        = PH_H1;
    end else begin
      case (ph)
        PH_H1: begin
          first_row[15:8] = b;
          ph              = PH_H2;
        end
        PH_H2: begin
          last_row = {8'h00, b};
          ph       = PH_H3;
        end
        PH_H3: begin
          last_row[15:8] = b;
          cur_row        = first_row;
          check_row(fend);
        end
        PH_COUNT: begin
          runs_left = b;
          if (b == 8'd0) begin
            advance_row(fend);
          end else begin
            ph = PH_X0;
          end
        end
        PH_X0: begin
          run_x = {8'h00, b};
          ph    = PH_X1;
        end
        PH_X1: begin
          run_x[15:8] = b;
          ph          = PH_LEN;
        end
        PH_LEN: begin
          span_addr = 32'(cur_row) * 32'(FRAME_WIDTH) + 32'(run_x);
          if (span_addr >= PIXELS) begin
            fabort = 1'b1;
            ph     = PH_IDLE;
          end else if (b == 8'd0) begin
            ph = PH_FILLV;
          end else begin
            lit_left  = b;
            skip_span = (span_addr + 32'(b) > PIXELS);
            ph        = PH_LIT;
          end
        end
        PH_FILLV: begin
          fill_val = b;
          ph       = PH_FILLN;
        end
        PH_FILLN: begin
          if (b != 8'd0 && span_addr + 32'(b) <= PIXELS) begin
            we                = 1'b1;
            res.pixel_address = span_addr[ADDR_W-1:0];
            res.pixel_value   = fill_val;
            res.span_length   = b;
          end
          close_run(fend);
        end
        PH_LIT: begin
          if (!skip_span) begin
            we                = 1'b1;
            res.pixel_address = span_addr[ADDR_W-1:0];
            res.pixel_value   = b;
            res.span_length   = 8'd1;
          end
          span_addr = (span_addr + 32'd1) & 32'h00FF_FFFF;
          lit_left  = lit_left - 8'd1;
          if (lit_left == 8'd0) begin
            close_run(fend);
          end
        end
        default: begin
          ph = PH_IDLE;
        end
      endcase
    end
    res.write_enable = we;
    res.frame_end    = fend;
    res.frame_abort  = fabort;
    has_result       = we | fend | fabort;
  endtask

  // Results are compared before the byte of the same edge is predicted; a byte
  // can never produce its result at the edge that accepts it.
  always @(posedge clk) begin : watch_channels
    result_t want;
    result_t predicted;
    logic    has_result;
    if (rst) begin
      ph        = PH_IDLE;
      first_row = '0;
      last_row  = '0;
      cur_row   = '0;
      runs_left = '0;
      run_x     = '0;
      lit_left  = '0;
      span_addr = '0;
      fill_val  = '0;
      skip_span = 1'b0;
      span_expect_q.delete();
      pending_results = 0;
    end else begin
      // Result transaction: check every field against the oldest expectation.
      if (out_valid && !out_stall) begin
        if (span_expect_q.size() == 0) begin
          report_mismatch("result with nothing expected", 0, 0);
        end else begin
          want = span_expect_q.pop_front();
          if (write_enable !== want.write_enable)
            report_mismatch("write_enable", write_enable, want.write_enable);
          if (pixel_address !== want.pixel_address)
            report_mismatch("pixel_address", pixel_address, want.pixel_address);
          if (pixel_value !== want.pixel_value)
            report_mismatch("pixel_value", pixel_value, want.pixel_value);
          if (span_length !== want.span_length)
            report_mismatch("span_length", span_length, want.span_length);
          if (frame_end !== want.frame_end)
            report_mismatch("frame_end", frame_end, want.frame_end);
          if (frame_abort !== want.frame_abort)
            report_mismatch("frame_abort", frame_abort, want.frame_abort);
        end
      end
      // Byte transaction: advance the shadow parser.
      if (in_valid && !in_stall) begin
        decode_byte(data_byte, frame_start, has_result, predicted);
        if (has_result) begin
          span_expect_q = {span_expect_q, predicted};
        end
      end
      pending_results = span_expect_q.size();
    end
  end

endmodule

@@ tb/sv/tb_row_rle_delta_frame_decoder.sv @@
`timescale 1ns / 1ps
// Top of the testbench for the row run-length delta frame decoder: clock, reset,
// byte stimulus, receiver stalls, watchdog and verdict.
// Depends on rrd_pkg, row_rle_delta_frame_decoder and rrd_span_checker.
module tb_row_rle_delta_frame_decoder;
  import rrd_pkg::*;

  localparam int FRAME_WIDTH     = 640;
  localparam int FRAME_HEIGHT    = 480;
  localparam int ITEMS_PER_PHASE = 600;
  localparam int STALL_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 10;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              in_valid    = 1'b0;
  logic [BYTE_W-1:0] data_byte   = '0;
  logic              frame_start = 1'b0;
  logic              out_stall   = 1'b0;
  wire               in_stall;
  wire               out_valid;
  wire               write_enable;
  wire  [ADDR_W-1:0] pixel_address;
  wire  [BYTE_W-1:0] pixel_value;
  wire  [BYTE_W-1:0] span_length;
  wire               frame_end;
  wire               frame_abort;
  int                error_count;
  int                pending_results;

  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    quiet_cycles  = 0;
  item_t frame_q[$];

  row_rle_delta_frame_decoder #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_top (.*);

  rrd_span_checker #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_span_check (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver stalls at random at the current rate.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Ends the run when no transaction has moved on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_row_rle_delta_frame_decoder: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_byte(input logic [BYTE_W-1:0] b, input logic start);
    item_t it;
    it.data_byte   = b;
    it.frame_start = start;
    frame_q = {frame_q, it};
  endtask

  task automatic put_header(input int unsigned first_r, input int unsigned last_r);
    add_byte(first_r[7:0], 1'b1);
    add_byte(first_r[15:8], 1'b0);
    add_byte(last_r[7:0], 1'b0);
    add_byte(last_r[15:8], 1'b0);
  endtask

  task automatic put_run_head(input int unsigned x, input int unsigned len);
    add_byte(x[7:0], 1'b0);
    add_byte(x[15:8], 1'b0);
    add_byte(len[7:0], 1'b0);
  endtask

  // Offers one byte after a random gap and holds it until the transaction.
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic start);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    frame_start <= start;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_queue();
    foreach (frame_q[i]) begin
      push_byte(frame_q[i].data_byte, frame_q[i].frame_start);
    end
    frame_q.delete();
  endtask

  // The sender holds off until every awaited result has come out.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // Builds one well-formed frame with random content. Rows stay few, and the
  // bottom rows and right edge are favoured so that spans reach the frame end.
  task automatic build_random_frame();
    int unsigned first_r;
    int unsigned last_r;
    int unsigned r;
    int unsigned k;
    int unsigned n;
    int unsigned x;
    int unsigned len;
    int unsigned sel;
    logic        aborted;
    sel = $urandom_range(0, 99);
    if (sel < 65) first_r = $urandom_range(0, FRAME_HEIGHT - 1);
    else if (sel < 90) first_r = $urandom_range(FRAME_HEIGHT - 3, FRAME_HEIGHT - 1);
    else first_r = $urandom_range(0, 65535);
    if ($urandom_range(0, 99) < 85) last_r = (first_r + $urandom_range(0, 2)) & 16'hFFFF;
    else last_r = $urandom_range(0, 65535);
    put_header(first_r, last_r);
    aborted = 1'b0;
    for (r = first_r; r <= last_r && r < FRAME_HEIGHT && !aborted; r++) begin
      n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      add_byte(n[7:0], 1'b0);
      for (k = 0; k < n && !aborted; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 80) x = $urandom_range(0, FRAME_WIDTH - 1);
        else if (sel < 93) x = $urandom_range(FRAME_WIDTH - 8, FRAME_WIDTH - 1);
        else x = $urandom_range(0, 65535);
        sel = $urandom_range(0, 99);
        if (sel < 35) len = 0;
        else if (sel < 97) len = $urandom_range(1, 6);
        else len = $urandom_range(1, 255);
        put_run_head(x, len);
        if (r * FRAME_WIDTH + x >= FRAME_WIDTH * FRAME_HEIGHT) begin
          aborted = 1'b1;
        end else if (len == 0) begin
          add_byte(8'($urandom_range(0, 255)), 1'b0);
          add_byte(($urandom_range(0, 99) < 15) ? 8'd0 : 8'($urandom_range(1, 255)), 1'b0);
        end else begin
          repeat (len) add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
      end
    end
  endtask

  // One phase of random frames at the given idle rates, then a full drain.
  task automatic run_random_phase(input int send_pct, input int recv_pct);
    int sent;
    int keep;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent          = 0;
    while (sent < ITEMS_PER_PHASE) begin
      // Stray bytes between frames, usually ignored by an idle parser.
      if ($urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)), 1'b0);
        send_queue();
      end
      build_random_frame();
      // Now and then the frame is cut short and the next one restarts the parser.
      if ($urandom_range(0, 99) < 10) begin
        keep = $urandom_range(1, frame_q.size());
        while (frame_q.size() > keep) frame_q.delete(frame_q.size() - 1);
      end
      sent += frame_q.size();
      send_queue();
    end
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 23;
    recv_idle_pct = 46;
    // A byte while idle is ignored.
    add_byte(8'h5A, 1'b0);
    // Empty row ranges: first row above last row, and first row at the frame height.
    put_header(5, 3);
    put_header(FRAME_HEIGHT, FRAME_HEIGHT + 31);
    // A partial header dropped by a restart, then five runs on the bottom row.
    add_byte(8'hFF, 1'b1);
    add_byte(8'hFF, 1'b0);
    put_header(FRAME_HEIGHT - 1, FRAME_HEIGHT - 1);
    add_byte(8'd5, 1'b0);
    // Fill that ends exactly on the last pixel.
    put_run_head(FRAME_WIDTH - 1, 0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'd1, 1'b0);
    // Fill that would pass the frame end, so it is skipped.
    put_run_head(FRAME_WIDTH - 1, 0);
    add_byte(8'hAB, 1'b0);
    add_byte(8'd2, 1'b0);
    // Fill of length zero writes nothing.
    put_run_head(0, 0);
    add_byte(8'h12, 1'b0);
    add_byte(8'd0, 1'b0);
    // Literal run that would pass the frame end.
    put_run_head(FRAME_WIDTH - 1, 2);
    add_byte(8'h11, 1'b0);
    add_byte(8'h22, 1'b0);
    // Last literal carries both its write and the end of the frame.
    put_run_head(0, 1);
    add_byte(8'h00, 1'b0);
    // An empty row, then a run that starts outside the frame.
    put_header(FRAME_HEIGHT - 2, FRAME_HEIGHT - 1);
    add_byte(8'd0, 1'b0);
    add_byte(8'd1, 1'b0);
    put_run_head(FRAME_WIDTH, 7);
    send_queue();
    drain_results();

    run_random_phase(23, 46);
    run_random_phase(46, 23);
    run_random_phase(0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results == 0) begin
      $display("tb_row_rle_delta_frame_decoder: done, clean");
    end else begin
      $display("tb_row_rle_delta_frame_decoder: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/rrd_pkg.sv
sv/rrd_in_stage.sv
sv/rrd_parser.sv
sv/rrd_out_stage.sv
sv/row_rle_delta_frame_decoder.sv
tb/sv/rrd_span_checker.sv
tb/sv/tb_row_rle_delta_frame_decoder.sv
